// ----- src/btog_pkg.sv -----
package btog_pkg;

    // Field widths fixed by the item formats
    localparam int IDX_W  = 16;
    localparam int OFF_W  = 32;
    localparam int RANK_W = 3;
    localparam int ETYP_W = 2;
    localparam int CFG_W  = 64;
    localparam int CIDX_W = 3;
    localparam int NUM_IN = 4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_RANK_A       = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SHAPE_A      = 3'd1;
    localparam logic [CIDX_W-1:0] REG_RANK_B       = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SHAPE_B      = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ELEMENT_TYPE = 3'd4;

    // Reset values of the configuration registers
    localparam logic [RANK_W-1:0] RANK_RST  = 3'd1;
    localparam logic [CFG_W-1:0]  SHAPE_RST = 64'h0001_0001_0001_0001;
    localparam logic [ETYP_W-1:0] ETYP_RST  = 2'd0;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INCOMPAT = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] index_d3;
        logic [IDX_W-1:0] index_d2;
        logic [IDX_W-1:0] index_d1;
        logic [IDX_W-1:0] index_d0;
    } in_item_t;

    typedef struct packed {
        logic [OFF_W-1:0]  byte_offset_a;
        logic [OFF_W-1:0]  byte_offset_b;
        logic [OFF_W-1:0]  byte_offset_result;
        logic [RANK_W-1:0] result_rank;
        logic [1:0]        status;
    } out_item_t;

    // Static control derived from configuration
    typedef struct packed {
        logic              busy;
        logic              incompat;
        logic              esz8;
        logic [RANK_W-1:0] rr;
    } btog_ctrl_t;

    // Per-lane findings passed to the merge stage
    typedef struct packed {
        logic oor;
        logic fail_a;
        logic fail_b;
        logic fail_r;
    } lane_flag_t;

endpackage

// ----- src/btog_cfg.sv -----
module btog_cfg
    import btog_pkg::*;
#(
    parameter int MAX_DIMS  = 4,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32,
    parameter int NLANE     = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output btog_ctrl_t            ctrl,
    output logic [NLANE-1:0]      a_one,
    output logic [NLANE-1:0]      b_one,
    output logic [NLANE-1:0]      in_rank,
    output logic [DIM_BITS-1:0]   dr [NLANE],
    output logic [ADDR_BITS-1:0]  sa [NLANE],
    output logic [ADDR_BITS-1:0]  sb [NLANE],
    output logic [ADDR_BITS-1:0]  sr [NLANE],
    output logic [NLANE-1:0]      big_a,
    output logic [NLANE-1:0]      big_b,
    output logic [NLANE-1:0]      big_r
);

    localparam int LW  = $clog2(NLANE);
    localparam int CW  = $clog2(NLANE + 1);
    localparam int PW  = ADDR_BITS + DIM_BITS;
    localparam int XW  = CFG_W + NLANE * DIM_BITS;
    localparam logic [3:0] MAXD = 4'(MAX_DIMS);

    logic [RANK_W-1:0] rank_a_reg, rank_a_next;
    logic [RANK_W-1:0] rank_b_reg, rank_b_next;
    logic [CFG_W-1:0]  shape_a_reg, shape_a_next;
    logic [CFG_W-1:0]  shape_b_reg, shape_b_next;
    logic [ETYP_W-1:0] etyp_reg, etyp_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    logic [ADDR_BITS-1:0] sa_reg [NLANE];
    logic [ADDR_BITS-1:0] sb_reg [NLANE];
    logic [ADDR_BITS-1:0] sr_reg [NLANE];
    logic [NLANE-1:0]     bga_reg, bgb_reg, bgr_reg;

    logic [RANK_W-1:0]   ra, rb, rr;
    logic [XW-1:0]       xa, xb;
    logic [DIM_BITS-1:0] da [NLANE];
    logic [DIM_BITS-1:0] db [NLANE];
    logic [DIM_BITS-1:0] drc [NLANE];
    logic [NLANE-1:0]    bad;
    logic                busy;
    logic [LW-1:0]       widx, pidx;
    logic [CW-1:0]       cnt_m1;
    logic [PW-1:0]       prod_a, prod_b, prod_r;

    // Register writes
    always_comb
    begin
        rank_a_next  = rank_a_reg;
        rank_b_next  = rank_b_reg;
        shape_a_next = shape_a_reg;
        shape_b_next = shape_b_reg;
        etyp_next    = etyp_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_RANK_A:       rank_a_next  = cfg_data[RANK_W-1:0];
                REG_SHAPE_A:      shape_a_next = cfg_data;
                REG_RANK_B:       rank_b_next  = cfg_data[RANK_W-1:0];
                REG_SHAPE_B:      shape_b_next = cfg_data;
                REG_ELEMENT_TYPE: etyp_next    = cfg_data[ETYP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective ranks, saturated at MAX_DIMS
    always_comb
    begin
        ra = ({1'b0, rank_a_reg} > MAXD) ? MAXD[RANK_W-1:0] : rank_a_reg;
        rb = ({1'b0, rank_b_reg} > MAXD) ? MAXD[RANK_W-1:0] : rank_b_reg;
        rr = (ra > rb) ? ra : rb;
        xa = {{(XW-CFG_W){1'b0}}, shape_a_reg};
        xb = {{(XW-CFG_W){1'b0}}, shape_b_reg};
    end

    // Right-aligned dimensions and broadcast result shape
    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            da[k] = (4'(k) < {1'b0, ra}) ? xa[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
            db[k] = (4'(k) < {1'b0, rb}) ? xb[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
            in_rank[k] = (4'(k) < {1'b0, rr});
            a_one[k] = (da[k] == DIM_BITS'(1));
            b_one[k] = (db[k] == DIM_BITS'(1));
            bad[k] = 1'b0;
            if (da[k] == db[k] || b_one[k])
                drc[k] = da[k];
            else if (a_one[k])
                drc[k] = db[k];
            else
            begin
                drc[k] = '0;
                bad[k] = in_rank[k];
            end
            dr[k] = drc[k];
        end
    end

    // Stride sequencer: one dimension per cycle after reset or a write
    assign busy   = (cnt_reg < CW'(NLANE));
    assign cnt_m1 = cnt_reg - CW'(1);
    assign widx   = cnt_reg[LW-1:0];
    assign pidx   = cnt_m1[LW-1:0];
    assign prod_a = PW'(sa_reg[pidx]) * PW'(da[pidx]);
    assign prod_b = PW'(sb_reg[pidx]) * PW'(db[pidx]);
    assign prod_r = PW'(sr_reg[pidx]) * PW'(drc[pidx]);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cfg_we)
            cnt_next = '0;
        else if (busy)
            cnt_next = cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_a_reg  <= RANK_RST;
            rank_b_reg  <= RANK_RST;
            shape_a_reg <= SHAPE_RST;
            shape_b_reg <= SHAPE_RST;
            etyp_reg    <= ETYP_RST;
            cnt_reg     <= '0;
        end
        else
        begin
            rank_a_reg  <= rank_a_next;
            rank_b_reg  <= rank_b_next;
            shape_a_reg <= shape_a_next;
            shape_b_reg <= shape_b_next;
            etyp_reg    <= etyp_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Stride table; a big flag sticks once the prefix product passes the cap
    always_ff @(posedge clk)
    begin
        if (busy && !cfg_we)
        begin
            if (cnt_reg == '0)
            begin
                sa_reg[widx]  <= ADDR_BITS'(1);
                sb_reg[widx]  <= ADDR_BITS'(1);
                sr_reg[widx]  <= ADDR_BITS'(1);
                bga_reg[widx] <= 1'b0;
                bgb_reg[widx] <= 1'b0;
                bgr_reg[widx] <= 1'b0;
            end
            else
            begin
                sa_reg[widx]  <= prod_a[ADDR_BITS-1:0];
                sb_reg[widx]  <= prod_b[ADDR_BITS-1:0];
                sr_reg[widx]  <= prod_r[ADDR_BITS-1:0];
                bga_reg[widx] <= bga_reg[pidx] | (prod_a[PW-1:ADDR_BITS] != '0);
                bgb_reg[widx] <= bgb_reg[pidx] | (prod_b[PW-1:ADDR_BITS] != '0);
                bgr_reg[widx] <= bgr_reg[pidx] | (prod_r[PW-1:ADDR_BITS] != '0);
            end
        end
    end

    assign sa    = sa_reg;
    assign sb    = sb_reg;
    assign sr    = sr_reg;
    assign big_a = bga_reg;
    assign big_b = bgb_reg;
    assign big_r = bgr_reg;

    always_comb
    begin
        ctrl.busy     = busy;
        ctrl.incompat = (ra == '0) || (rb == '0) || (bad != '0);
        ctrl.esz8     = etyp_reg[1];
        ctrl.rr       = rr;
    end

endmodule

// ----- src/btog_lane.sv -----
module btog_lane
    import btog_pkg::*;
#(
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 load,
    input  logic [IDX_W-1:0]     idx,
    input  logic                 a_one,
    input  logic                 b_one,
    input  logic                 in_rank,
    input  logic [DIM_BITS-1:0]  dr,
    input  logic [ADDR_BITS-1:0] sa,
    input  logic [ADDR_BITS-1:0] sb,
    input  logic [ADDR_BITS-1:0] sr,
    input  logic                 big_a,
    input  logic                 big_b,
    input  logic                 big_r,
    output logic [ADDR_BITS-1:0] term_a_reg,
    output logic [ADDR_BITS-1:0] term_b_reg,
    output logic [ADDR_BITS-1:0] term_r_reg,
    output lane_flag_t           flag_reg
);

    localparam int PW   = ADDR_BITS + IDX_W;
    localparam int CMPW = (IDX_W > DIM_BITS) ? IDX_W : DIM_BITS;

    logic [IDX_W-1:0]     ia, ib;
    logic [PW-1:0]        pa, pb, pr;
    logic [ADDR_BITS-1:0] term_a_next, term_b_next, term_r_next;
    lane_flag_t           flag_next;

    // Broadcast dimensions of a source take index zero
    assign ia = a_one ? '0 : idx;
    assign ib = b_one ? '0 : idx;

    assign pa = PW'(ia) * PW'(sa);
    assign pb = PW'(ib) * PW'(sb);
    assign pr = PW'(idx) * PW'(sr);

    // Term and per-term overflow for the three offsets
    always_comb
    begin
        term_a_next = pa[ADDR_BITS-1:0];
        term_b_next = pb[ADDR_BITS-1:0];
        term_r_next = pr[ADDR_BITS-1:0];
        flag_next.fail_a = (ia != '0)
            && (big_a || (sa == '0) || (pa[PW-1:ADDR_BITS] != '0));
        flag_next.fail_b = (ib != '0)
            && (big_b || (sb == '0) || (pb[PW-1:ADDR_BITS] != '0));
        flag_next.fail_r = (idx != '0)
            && (big_r || (sr == '0) || (pr[PW-1:ADDR_BITS] != '0));
        // Range check; outside the rank only index zero is legal
        flag_next.oor = in_rank ? (CMPW'(idx) >= CMPW'(dr)) : (idx != '0);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_a_reg <= term_a_next;
            term_b_reg <= term_b_next;
            term_r_reg <= term_r_next;
            flag_reg   <= flag_next;
        end
    end

endmodule

// ----- src/btog_merge.sv -----
module btog_merge
    import btog_pkg::*;
#(
    parameter int ADDR_BITS = 32,
    parameter int NLANE     = 4
)
(
    input  logic                 clk,
    input  logic                 load,
    input  btog_ctrl_t           ctrl,
    input  lane_flag_t           flags [NLANE],
    input  logic [ADDR_BITS-1:0] term_a [NLANE],
    input  logic [ADDR_BITS-1:0] term_b [NLANE],
    input  logic [ADDR_BITS-1:0] term_r [NLANE],
    output out_item_t            item_reg
);

    localparam int SUM_W = ADDR_BITS + $clog2(NLANE) + 1;

    logic [SUM_W-1:0] sum_a, sum_b, sum_r;
    logic             any_oor, any_fail, ovf;
    out_item_t        item_next;

    // Overflow once scaled by the element size
    function automatic logic too_big(input logic [SUM_W-1:0] s, input logic e8);
        logic r;
        if (e8)
            r = (s[SUM_W-1:ADDR_BITS-3] != '0);
        else
            r = (s[SUM_W-1:ADDR_BITS-2] != '0);
        return r;
    endfunction

    // Byte offset, scaled and cut to the output width
    function automatic logic [OFF_W-1:0] scale(input logic [SUM_W-1:0] s, input logic e8);
        logic [ADDR_BITS-1:0]       b;
        logic [OFF_W+ADDR_BITS-1:0] x;
        if (e8)
            b = {s[ADDR_BITS-4:0], 3'b000};
        else
            b = {s[ADDR_BITS-3:0], 2'b00};
        x = {{OFF_W{1'b0}}, b};
        return x[OFF_W-1:0];
    endfunction

    // Sum lane terms and gather lane flags
    always_comb
    begin
        sum_a    = '0;
        sum_b    = '0;
        sum_r    = '0;
        any_oor  = 1'b0;
        any_fail = 1'b0;
        for (int k = 0; k < NLANE; k++)
        begin
            sum_a    = sum_a + SUM_W'(term_a[k]);
            sum_b    = sum_b + SUM_W'(term_b[k]);
            sum_r    = sum_r + SUM_W'(term_r[k]);
            any_oor  = any_oor | flags[k].oor;
            any_fail = any_fail | flags[k].fail_a | flags[k].fail_b | flags[k].fail_r;
        end
        ovf = any_fail || too_big(sum_a, ctrl.esz8) || too_big(sum_b, ctrl.esz8)
            || too_big(sum_r, ctrl.esz8);
    end

    // Status priority: incompatible, out of range, overflow
    always_comb
    begin
        item_next.result_rank        = ctrl.rr;
        item_next.byte_offset_a      = '0;
        item_next.byte_offset_b      = '0;
        item_next.byte_offset_result = '0;
        if (ctrl.incompat)
            item_next.status = ST_INCOMPAT;
        else if (any_oor)
            item_next.status = ST_RANGE;
        else if (ovf)
            item_next.status = ST_OVERFLOW;
        else
        begin
            item_next.status             = ST_OK;
            item_next.byte_offset_a      = scale(sum_a, ctrl.esz8);
            item_next.byte_offset_b      = scale(sum_b, ctrl.esz8);
            item_next.byte_offset_result = scale(sum_r, ctrl.esz8);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

endmodule

// ----- src/broadcast_tensor_offset_generator_unit.sv -----
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall in_item_t  (index_d0..index_d3)
// rsp       out        rsp_valid/rsp_stall out_item_t (offsets, rank, status)
// cfg       in         cfg_we              cfg_index, cfg_data (no read-back)
//
// One item per cycle while req_stall is low; the lane registers take an item at its
// accept edge and the merge stage then loads the output register once it is free,
// which raises rsp_valid; a stalled output holds the item in the lane registers.
// Reset and every configuration write start the stride sequencer, one
// dimension per cycle; req_stall stays high until it has covered all lanes.
// rsp_stall holds the output register; the lane stage still takes one more item.
module broadcast_tensor_offset_generator_unit
    import btog_pkg::*;
#(
    parameter int MAX_DIMS  = 4,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  in_item_t          req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output out_item_t         rsp_item,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int NLANE = (MAX_DIMS > NUM_IN) ? MAX_DIMS : NUM_IN;

    btog_ctrl_t           ctrl;
    logic [NLANE-1:0]     a_one, b_one, in_rank, big_a, big_b, big_r;
    logic [DIM_BITS-1:0]  dr [NLANE];
    logic [ADDR_BITS-1:0] sa [NLANE];
    logic [ADDR_BITS-1:0] sb [NLANE];
    logic [ADDR_BITS-1:0] sr [NLANE];
    logic [ADDR_BITS-1:0] term_a [NLANE];
    logic [ADDR_BITS-1:0] term_b [NLANE];
    logic [ADDR_BITS-1:0] term_r [NLANE];
    lane_flag_t           flags [NLANE];
    logic [NUM_IN*IDX_W-1:0] req_vec;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s2_free, s2_load, accept;

    btog_cfg #(
        .MAX_DIMS  (MAX_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS),
        .NLANE     (NLANE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .a_one     (a_one),
        .b_one     (b_one),
        .in_rank   (in_rank),
        .dr        (dr),
        .sa        (sa),
        .sb        (sb),
        .sr        (sr),
        .big_a     (big_a),
        .big_b     (big_b),
        .big_r     (big_r)
    );

    assign req_vec = req_item;

    // One lane per dimension
    for (genvar k = 0; k < NLANE; k++)
    begin : g_lane
        logic [IDX_W-1:0] idx;
        if (k < NUM_IN)
        begin : g_in
            assign idx = req_vec[k*IDX_W +: IDX_W];
        end
        else
        begin : g_zero
            assign idx = '0;
        end

        btog_lane #(
            .DIM_BITS  (DIM_BITS),
            .ADDR_BITS (ADDR_BITS)
        ) u_lane (
            .clk        (clk),
            .load       (accept),
            .idx        (idx),
            .a_one      (a_one[k]),
            .b_one      (b_one[k]),
            .in_rank    (in_rank[k]),
            .dr         (dr[k]),
            .sa         (sa[k]),
            .sb         (sb[k]),
            .sr         (sr[k]),
            .big_a      (big_a[k]),
            .big_b      (big_b[k]),
            .big_r      (big_r[k]),
            .term_a_reg (term_a[k]),
            .term_b_reg (term_b[k]),
            .term_r_reg (term_r[k]),
            .flag_reg   (flags[k])
        );
    end

    btog_merge #(
        .ADDR_BITS (ADDR_BITS),
        .NLANE     (NLANE)
    ) u_merge (
        .clk      (clk),
        .load     (s2_load),
        .ctrl     (ctrl),
        .flags    (flags),
        .term_a   (term_a),
        .term_b   (term_b),
        .term_r   (term_r),
        .item_reg (rsp_item)
    );

    // Pipeline control
    assign s2_free   = !out_valid_reg || !rsp_stall;
    assign s2_load   = s1_valid_reg && s2_free;
    assign req_stall = ctrl.busy || (s1_valid_reg && !s2_free);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_load)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A config write blocks new items while strides are rebuilt
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> req_stall)
        else $error("item taken right after a config write");

    // Non-ok status carries zero offsets
    a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status != ST_OK) |->
            (rsp_item.byte_offset_a == '0) && (rsp_item.byte_offset_b == '0)
            && (rsp_item.byte_offset_result == '0))
        else $error("offsets not cleared on error status");

    // A zero result rank only arises from incompatible ranks
    a_rank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.result_rank == '0) |-> (rsp_item.status == ST_INCOMPAT))
        else $error("zero result rank with status other than incompatible");

    // A lane-stage item with room ahead reaches the output next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_free |=> rsp_valid)
        else $error("lane stage item lost");

endmodule
